// File: src/bas_pkg.sv
// Package: shared constants and codes for the button auto-repeat and sleep qualifier.
`timescale 1ns / 1ps
package bas_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 1;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 8;

  localparam logic [CFG_W-1:0] SLEEP_TIMEOUT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = 16'd350;

  // Hold-length thresholds and repeat intervals, in ms
  localparam int HOLD_T3 = 4000;
  localparam int HOLD_T2 = 2500;
  localparam int HOLD_T1 = 1200;
  localparam int RPT_I3  = 10;
  localparam int RPT_I2  = 35;
  localparam int RPT_I1  = 70;
  localparam int RPT_I0  = 140;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SLEEP_TIMEOUT = 1'b0,
    REG_HOLD_DELAY    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LEFT   = 2'd1,
    ACT_RIGHT  = 2'd2,
    ACT_CENTER = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CHG_NONE  = 2'd0,
    CHG_SLEPT = 2'd1,
    CHG_WOKE  = 2'd2
  } sleep_chg_t;

  typedef struct packed {
    logic held;
    logic click;
    logic allow;
  } btn_ctl_t;

endpackage

// File: src/bas_btn_track.sv
// Hold-timer update and auto-repeat decision for one button.
`timescale 1ns / 1ps
module bas_btn_track #(
  parameter int TIME_BITS = bas_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0]   now,
  input  bas_pkg::btn_ctl_t      ctl,
  input  logic [bas_pkg::CFG_W-1:0] hold_delay,
  input  logic [TIME_BITS-1:0]   begin_cur,
  input  logic [TIME_BITS-1:0]   next_cur,
  output logic [TIME_BITS-1:0]   begin_upd,
  output logic [TIME_BITS-1:0]   next_upd,
  output logic                   fire
);

  logic [TIME_BITS-1:0] first_due;
  logic [TIME_BITS-1:0] held_for;
  logic [TIME_BITS-1:0] interval;

  assign first_due = now + TIME_BITS'(hold_delay);
  assign held_for  = now - begin_cur;

  always_comb begin
    priority if (held_for > TIME_BITS'(bas_pkg::HOLD_T3)) interval = TIME_BITS'(bas_pkg::RPT_I3);
    else if (held_for > TIME_BITS'(bas_pkg::HOLD_T2)) interval = TIME_BITS'(bas_pkg::RPT_I2);
    else if (held_for > TIME_BITS'(bas_pkg::HOLD_T1)) interval = TIME_BITS'(bas_pkg::RPT_I1);
    else interval = TIME_BITS'(bas_pkg::RPT_I0);
  end

  always_comb begin
    begin_upd = begin_cur;
    next_upd  = next_cur;
    fire      = 1'b0;
    if (ctl.click) begin
      begin_upd = now;
      next_upd  = first_due;
    end else if (!ctl.held) begin
      begin_upd = '0;
      next_upd  = '0;
    end
    if (ctl.allow && ctl.held && !ctl.click) begin
      if (begin_cur == '0) begin
        begin_upd = now;
        next_upd  = first_due;
      end else if (next_cur != '0 && now >= next_cur) begin
        next_upd = now + interval;
        fire     = 1'b1;
      end
    end
  end

endmodule

// File: src/button_autorepeat_sleep_qualifier_unit.sv
// Top level: button auto-repeat and display-sleep qualifier with stream ports.
`timescale 1ns / 1ps
// One result transaction per input transaction. An input is captured in an
// input register, qualified by single-pass logic against the activity, sleep
// and hold-timer state, and lands in the result register on the first edge
// after it was accepted at which the result register is empty or being read;
// the state updates on that same edge, so a new input can be taken every
// cycle while the result register is empty or being read. Result and input
// registers decouple the two sides: in_tready stays high while a result waits
// as long as the input register is free. Timestamps are modulo 2^TIME_BITS.
module button_autorepeat_sleep_qualifier_unit #(
  parameter int TIME_BITS = bas_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] now_ms, [32] left_held, [33] right_held, [34] center_held,
  // [35] left_clicked, [36] right_clicked, [37] center_clicked,
  // [38] repeat_allowed, [39] splash_busy
  input  logic [bas_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] action, [2] asleep, [4:3] sleep_change, [7:5] zero
  output logic [bas_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bas_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bas_pkg::CFG_W-1:0]       cfg_data
);

  logic [bas_pkg::CFG_W-1:0] sleep_to_r;
  logic [bas_pkg::CFG_W-1:0] hold_delay_r;

  logic                           in_valid_r;
  logic [bas_pkg::IN_DATA_W-1:0]  in_data_r;
  logic                           out_valid_r;
  logic [bas_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [bas_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic [TIME_BITS-1:0] last_act_r, last_act_nxt;
  logic                 sleeping_r, sleeping_nxt;
  logic [TIME_BITS-1:0] l_begin_r, l_begin_nxt, l_next_r, l_next_nxt;
  logic [TIME_BITS-1:0] r_begin_r, r_begin_nxt, r_next_r, r_next_nxt;

  logic advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Field unpack
  logic [TIME_BITS-1:0] now;
  logic lh, rh, ch, lc, rc, cc, allow, splash;

  assign now    = TIME_BITS'(in_data_r[bas_pkg::NOW_W-1:0]);
  assign lh     = in_data_r[32];
  assign rh     = in_data_r[33];
  assign ch     = in_data_r[34];
  assign lc     = in_data_r[35];
  assign rc     = in_data_r[36];
  assign cc     = in_data_r[37];
  assign allow  = in_data_r[38];
  assign splash = in_data_r[39];

  bas_pkg::btn_ctl_t    l_ctl, r_ctl;
  logic [TIME_BITS-1:0] l_begin_upd, l_next_upd, r_begin_upd, r_next_upd;
  logic                 l_fire, r_fire;

  assign l_ctl = '{held: lh, click: lc, allow: allow};
  assign r_ctl = '{held: rh, click: rc, allow: allow};

  bas_btn_track #(.TIME_BITS(TIME_BITS)) u_left (
    .now        (now),
    .ctl        (l_ctl),
    .hold_delay (hold_delay_r),
    .begin_cur  (l_begin_r),
    .next_cur   (l_next_r),
    .begin_upd  (l_begin_upd),
    .next_upd   (l_next_upd),
    .fire       (l_fire)
  );

  bas_btn_track #(.TIME_BITS(TIME_BITS)) u_right (
    .now        (now),
    .ctl        (r_ctl),
    .hold_delay (hold_delay_r),
    .begin_cur  (r_begin_r),
    .next_cur   (r_next_r),
    .begin_upd  (r_begin_upd),
    .next_upd   (r_next_upd),
    .fire       (r_fire)
  );

  logic [TIME_BITS-1:0] idle_time;
  assign idle_time = now - last_act_r;

  bas_pkg::action_t    action;
  bas_pkg::sleep_chg_t change;

  always_comb begin
    last_act_nxt = last_act_r;
    sleeping_nxt = sleeping_r;
    l_begin_nxt  = l_begin_r;
    l_next_nxt   = l_next_r;
    r_begin_nxt  = r_begin_r;
    r_next_nxt   = r_next_r;
    action       = bas_pkg::ACT_NONE;
    change       = bas_pkg::CHG_NONE;
    if ((lh || rh || ch) && sleeping_r) begin
      // wake: clicks swallowed
      last_act_nxt = now;
      sleeping_nxt = 1'b0;
      l_begin_nxt  = '0;
      l_next_nxt   = '0;
      r_begin_nxt  = '0;
      r_next_nxt   = '0;
      change       = bas_pkg::CHG_WOKE;
    end else if (!(lh || rh || ch) && !sleeping_r && last_act_r != '0 &&
                 idle_time > TIME_BITS'(sleep_to_r)) begin
      sleeping_nxt = 1'b1;
      l_begin_nxt  = '0;
      l_next_nxt   = '0;
      r_begin_nxt  = '0;
      r_next_nxt   = '0;
      change       = bas_pkg::CHG_SLEPT;
    end else begin
      // a held button refreshes activity, so timeout cannot trigger here
      if (lh || rh || ch || lc || rc || cc) last_act_nxt = now;
      if (!splash) begin
        l_begin_nxt = l_begin_upd;
        l_next_nxt  = l_next_upd;
        r_begin_nxt = r_begin_upd;
        r_next_nxt  = r_next_upd;
        priority if (lc || l_fire) action = bas_pkg::ACT_LEFT;
        else if (rc || r_fire) action = bas_pkg::ACT_RIGHT;
        else if (cc) action = bas_pkg::ACT_CENTER;
        else action = bas_pkg::ACT_NONE;
      end
    end
    out_data_nxt = {3'b000, change, sleeping_nxt, action};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_to_r   <= bas_pkg::SLEEP_TIMEOUT_RST;
      hold_delay_r <= bas_pkg::HOLD_DELAY_RST;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_act_r   <= '0;
      sleeping_r   <= 1'b0;
      l_begin_r    <= '0;
      l_next_r     <= '0;
      r_begin_r    <= '0;
      r_next_r     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (bas_pkg::cfg_reg_t'(cfg_addr))
          bas_pkg::REG_SLEEP_TIMEOUT: sleep_to_r   <= cfg_data;
          bas_pkg::REG_HOLD_DELAY:    hold_delay_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_tready) in_valid_r <= in_tvalid;
      if (!out_valid_r || out_tready) out_valid_r <= in_valid_r;
      if (advance) begin
        last_act_r <= last_act_nxt;
        sleeping_r <= sleeping_nxt;
        l_begin_r  <= l_begin_nxt;
        l_next_r   <= l_next_nxt;
        r_begin_r  <= r_begin_nxt;
        r_next_r   <= r_next_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata;
    if (advance) out_data_r <= out_data_nxt;
  end

endmodule

// File: tb/testbench.sv
// Testbench for the button auto-repeat and display-sleep qualifier: directed ticks, then random.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    bas_pkg::action_t    act;
    logic                asleep;
    bas_pkg::sleep_chg_t chg;
  } tick_res_t;

  typedef struct {
    logic [31:0] b;
    logic [31:0] n;
    bit          fire;
  } hold_t;

  typedef struct {
    logic [bas_pkg::IN_DATA_W-1:0] d;
    bit                            typed;
    tick_res_t                     want;
  } dir_row_t;

  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_STALL = 300;
  localparam int SEG_ITEMS  = 235;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [bas_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bas_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [bas_pkg::CFG_ADDR_W-1:0] cfg_addr   = bas_pkg::REG_SLEEP_TIMEOUT;
  logic [bas_pkg::CFG_W-1:0]      cfg_data   = '0;

  // per-transaction tag: take the typed expectation instead of the predictor's
  bit        cur_typed = 1'b0;
  tick_res_t cur_want  = '0;

  // predictor state
  logic [bas_pkg::CFG_W-1:0] sleep_tmo  = bas_pkg::SLEEP_TIMEOUT_RST;
  logic [bas_pkg::CFG_W-1:0] hold_dly   = bas_pkg::HOLD_DELAY_RST;
  logic [31:0]      last_act   = '0;
  logic             is_asleep  = 1'b0;
  logic [31:0]      l_begin    = '0;
  logic [31:0]      l_next     = '0;
  logic [31:0]      r_begin    = '0;
  logic [31:0]      r_next     = '0;

  tick_res_t pending_ticks[$];
  dir_row_t  dir_tab[$];

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit long_stall_go = 1'b0;
  bit stall_taken   = 1'b0;
  int stall_left    = 0;

  // random tick generator state
  logic [31:0] t_now = 32'd1000;
  int          hold_left[3] = '{0, 0, 0};

  button_autorepeat_sleep_qualifier_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [bas_pkg::IN_DATA_W-1:0] pk(logic [31:0] now,
                                                         bit lh, bit rh, bit ch,
                                                         bit lc, bit rc, bit cc,
                                                         bit al, bit sp);
    return {sp, al, cc, rc, lc, ch, rh, lh, now};
  endfunction

  function automatic dir_row_t tick_row(logic [bas_pkg::IN_DATA_W-1:0] d, bit typed,
                                        bas_pkg::action_t a, logic s,
                                        bas_pkg::sleep_chg_t c);
    dir_row_t r;
    r.d = d;
    r.typed = typed;
    r.want.act = a;
    r.want.asleep = s;
    r.want.chg = c;
    return r;
  endfunction

  function automatic logic [31:0] repeat_gap(logic [31:0] held_for);
    if (held_for > bas_pkg::HOLD_T3) return bas_pkg::RPT_I3;
    if (held_for > bas_pkg::HOLD_T2) return bas_pkg::RPT_I2;
    if (held_for > bas_pkg::HOLD_T1) return bas_pkg::RPT_I1;
    return bas_pkg::RPT_I0;
  endfunction

  function automatic hold_t advance_hold(logic [31:0] now, bit held, bit click, bit allow,
                                         logic [31:0] b, logic [31:0] n);
    hold_t h;
    h.b = b;
    h.n = n;
    h.fire = 1'b0;
    if (click) begin
      h.b = now;
      h.n = now + {16'd0, hold_dly};
    end else if (!held) begin
      h.b = '0;
      h.n = '0;
    end
    if (allow && held && !click) begin
      if (h.b == 0) begin
        h.b = now;
        h.n = now + {16'd0, hold_dly};
      end else if (h.n != 0 && now >= h.n) begin
        h.n = now + repeat_gap(now - h.b);
        h.fire = 1'b1;
      end
    end
    return h;
  endfunction

  function automatic void clear_hold_timers();
    l_begin = '0;
    l_next  = '0;
    r_begin = '0;
    r_next  = '0;
  endfunction

  function automatic tick_res_t qualify_tick(logic [bas_pkg::IN_DATA_W-1:0] d);
    tick_res_t   r;
    hold_t       hl;
    hold_t       hr;
    logic [31:0] now;
    bit          lh, rh, ch, lc, rc, cc, al, sp;
    bit          woke;
    now = d[31:0];
    {sp, al, cc, rc, lc, ch, rh, lh} = d[39:32];
    r.act = bas_pkg::ACT_NONE;
    r.chg = bas_pkg::CHG_NONE;
    woke = 1'b0;
    if (lh || rh || ch) begin
      last_act = now;
      if (is_asleep) begin
        is_asleep = 1'b0;
        clear_hold_timers();
        r.chg = bas_pkg::CHG_WOKE;
        woke = 1'b1;
      end
    end
    if (!woke) begin
      if (!is_asleep && last_act != 0 && (now - last_act) > {16'd0, sleep_tmo}) begin
        is_asleep = 1'b1;
        clear_hold_timers();
        r.chg = bas_pkg::CHG_SLEPT;
      end else begin
        if (lc || rc || cc) last_act = now;
        if (!sp) begin
          hl = advance_hold(now, lh, lc, al, l_begin, l_next);
          hr = advance_hold(now, rh, rc, al, r_begin, r_next);
          l_begin = hl.b;
          l_next  = hl.n;
          r_begin = hr.b;
          r_next  = hr.n;
          if (lc || hl.fire) r.act = bas_pkg::ACT_LEFT;
          else if (rc || hr.fire) r.act = bas_pkg::ACT_RIGHT;
          else if (cc) r.act = bas_pkg::ACT_CENTER;
        end
      end
    end
    r.asleep = is_asleep;
    return r;
  endfunction

  // mostly plausible button sessions on a moving clock, some raw noise
  function automatic logic [bas_pkg::IN_DATA_W-1:0] gen_tick();
    logic [63:0] raw;
    bit   [2:0]  hb;
    int          r;
    r = $urandom_range(99);
    if (r < 8) begin
      raw = {$urandom, $urandom};
      return raw[bas_pkg::IN_DATA_W-1:0];
    end
    r = $urandom_range(99);
    if (r < 70) t_now += $urandom_range(60);
    else if (r < 90) t_now += $urandom_range(400, 61);
    else if (r < 96) t_now += $urandom_range(70000, 20000);
    else if (r < 98) t_now = $urandom;
    else t_now = 32'hFFFF_FFFF - $urandom_range(2000);
    for (int i = 0; i < 3; i++) begin
      if (hold_left[i] > 0) begin
        hb[i] = 1'b1;
        hold_left[i]--;
      end else if ($urandom_range(99) < 6) begin
        hb[i] = 1'b1;
        hold_left[i] = (i == 2) ? $urandom_range(4) : $urandom_range(150);
      end else begin
        hb[i] = 1'b0;
      end
    end
    return pk(t_now, hb[0], hb[1], hb[2], $urandom_range(99) < 5, $urandom_range(99) < 5,
              $urandom_range(99) < 5, $urandom_range(99) < 90, $urandom_range(99) < 5);
  endfunction

  task automatic send_tick(logic [bas_pkg::IN_DATA_W-1:0] d, bit typed, tick_res_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_checked != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [bas_pkg::CFG_W-1:0] tmo, logic [bas_pkg::CFG_W-1:0] dly);
    cfg_valid <= 1'b1;
    cfg_addr  <= bas_pkg::REG_SLEEP_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk); while (!cfg_ready);
    cfg_addr  <= bas_pkg::REG_HOLD_DELAY;
    cfg_data  <= dly;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_stall_go && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= LONG_STALL;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // predict on input transactions, check on result transactions
  always @(posedge clk) begin
    tick_res_t p;
    tick_res_t w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        unique case (bas_pkg::cfg_reg_t'(cfg_addr))
          bas_pkg::REG_SLEEP_TIMEOUT: sleep_tmo = cfg_data;
          bas_pkg::REG_HOLD_DELAY:    hold_dly  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        p = qualify_tick(in_tdata);
        pending_ticks.push_back(cur_typed ? cur_want : p);
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (pending_ticks.size() == 0) begin
          $display("%0t: unexpected result transaction, got %h", $time, out_tdata);
          errors++;
        end else begin
          w = pending_ticks.pop_front();
          if (out_tdata[1:0] != w.act) begin
            $display("%0t: action expected %0d got %0d", $time, w.act, out_tdata[1:0]);
            errors++;
          end
          if (out_tdata[2] != w.asleep) begin
            $display("%0t: asleep expected %0d got %0d", $time, w.asleep, out_tdata[2]);
            errors++;
          end
          if (out_tdata[4:3] != w.chg) begin
            $display("%0t: sleep_change expected %0d got %0d", $time, w.chg, out_tdata[4:3]);
            errors++;
          end
          if (out_tdata[7:5] != 3'd0) begin
            $display("%0t: pad bits expected 0 got %0d", $time, out_tdata[7:5]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // reset settings, left held from 400 through the interval bands
    dir_tab.push_back(tick_row(pk(0, 0,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(100, 0,0,0, 1,0,0, 1,0), 1,
                               bas_pkg::ACT_LEFT, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(200, 0,0,0, 0,1,1, 1,0), 1,
                               bas_pkg::ACT_RIGHT, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(300, 0,0,0, 0,0,1, 1,0), 1,
                               bas_pkg::ACT_CENTER, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(400, 1,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(760, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(900, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(1700, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(2700, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(3000, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(4500, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(4505, 1,1,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(4600, 1,1,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(5000, 0,1,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(5100, 0,0,0, 0,0,1, 1,0), 1,
                               bas_pkg::ACT_CENTER, 0, bas_pkg::CHG_NONE));
    // timeout boundary, sleep, click while asleep, wake
    dir_tab.push_back(tick_row(pk(35100, 0,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(35101, 0,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 1, bas_pkg::CHG_SLEPT));
    dir_tab.push_back(tick_row(pk(35200, 0,0,0, 1,0,0, 1,0), 1,
                               bas_pkg::ACT_LEFT, 1, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(35300, 0,0,1, 0,0,1, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_WOKE));
    // hold across the timestamp wrap, repeat compare not wrap aware
    dir_tab.push_back(tick_row(pk(32'hFFFF_FFF0, 1,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(32'h10, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(32'h200, 1,0,0, 0,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    // activity at time zero reads as never active
    dir_tab.push_back(tick_row(pk(0, 1,0,0, 1,0,0, 1,0), 0,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(40000, 0,0,0, 0,0,0, 1,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    // repeat disallowed, splash busy, all bits set
    dir_tab.push_back(tick_row(pk(40100, 0,1,0, 0,0,0, 0,0), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(40200, 0,1,0, 1,0,0, 1,1), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));
    dir_tab.push_back(tick_row(pk(32'hFFFF_FFFF, 1,1,1, 1,1,1, 1,1), 1,
                               bas_pkg::ACT_NONE, 0, bas_pkg::CHG_NONE));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 27;
    rx_idle_pct <= 71;
    foreach (dir_tab[i]) send_tick(dir_tab[i].d, dir_tab[i].typed, dir_tab[i].want);

    for (int s = 0; s < 6; s++) begin
      drain();
      unique case (s)
        0: write_regs(bas_pkg::SLEEP_TIMEOUT_RST, bas_pkg::HOLD_DELAY_RST);
        1: write_regs(16'd0, 16'd0);
        2: write_regs(16'hFFFF, 16'hFFFF);
        3: write_regs(16'd2000, 16'd50);
        4: write_regs(16'($urandom_range(65535)), 16'($urandom_range(1000)));
        default: write_regs(16'd500, 16'd200);
      endcase
      if (s < 2) begin
        tx_idle_pct = 27;
        rx_idle_pct <= 71;
      end else if (s < 4) begin
        tx_idle_pct = 71;
        rx_idle_pct <= 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (s == 4) long_stall_go <= 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) send_tick(gen_tick(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_checked != n_sent) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_ticks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_ticks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
